/* rtl/nmab_pkg.sv */
`default_nettype none

package nmab_pkg;

  localparam int ByteW    = 8;
  localparam int TimeInW  = 32;
  localparam int BaudW    = 22;
  localparam int PeriodW  = 16;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_ENABLED         = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DEFAULT_BAUD    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_PROBE_PERIOD    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_HEALTHY_TIMEOUT = CfgIdxW'(3);

  localparam logic [ByteW-1:0] CHAR_NUL    = 8'h00;
  localparam logic [ByteW-1:0] CHAR_LF     = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_CR     = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CHAR_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] CHAR_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] CHAR_G      = 8'h47;

  localparam logic [BaudW-1:0] BAUD_9600   = 22'd9600;
  localparam logic [BaudW-1:0] BAUD_38400  = 22'd38400;
  localparam logic [BaudW-1:0] BAUD_57600  = 22'd57600;
  localparam logic [BaudW-1:0] BAUD_115200 = 22'd115200;

  localparam logic                ENABLED_RST         = 1'b1;
  localparam logic [BaudW-1:0]    DEFAULT_BAUD_RST    = 22'd9600;
  localparam logic [PeriodW-1:0]  PROBE_PERIOD_RST    = 16'd1800;
  localparam logic [PeriodW-1:0]  HEALTHY_TIMEOUT_RST = 16'd5000;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [ByteW-1:0]   byte_value;
    logic [TimeInW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic               enabled;
    logic [BaudW-1:0]   default_baud;
    logic [PeriodW-1:0] probe_period_ms;
    logic [PeriodW-1:0] healthy_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [BaudW-1:0] current_baud;
    logic             baud_changed;
    logic             stream_locked;
    logic             sentence_detected;
    logic             healthy;
  } res_t;

  // The entry after the first table match; no match behaves as the first entry.
  function automatic logic [BaudW-1:0] next_baud(input logic [BaudW-1:0] cur,
                                                 input logic [BaudW-1:0] dflt);
    logic [BaudW-1:0] nxt;
    if (cur == dflt) begin
      nxt = BAUD_9600;
    end else if (cur == BAUD_9600) begin
      nxt = BAUD_38400;
    end else if (cur == BAUD_38400) begin
      nxt = BAUD_57600;
    end else if (cur == BAUD_57600) begin
      nxt = BAUD_115200;
    end else if (cur == BAUD_115200) begin
      nxt = dflt;
    end else begin
      nxt = BAUD_9600;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

/* rtl/nmab_if.sv */
`default_nettype none

interface nmab_in_if;
  logic                             valid;
  logic                             ready;
  nmab_pkg::cmd_e                   command;
  logic [nmab_pkg::ByteW-1:0]       byte_value;
  logic [nmab_pkg::TimeInW-1:0]     now_ms;

  modport source (output valid, command, byte_value, now_ms, input ready);
  modport sink (input valid, command, byte_value, now_ms, output ready);
endinterface

interface nmab_out_if;
  logic                             valid;
  logic                             ready;
  logic [nmab_pkg::BaudW-1:0]       current_baud;
  logic                             baud_changed;
  logic                             stream_locked;
  logic                             sentence_detected;
  logic                             healthy;

  modport source (output valid, current_baud, baud_changed, stream_locked,
                  sentence_detected, healthy, input ready);
  modport sink (input valid, current_baud, baud_changed, stream_locked,
                sentence_detected, healthy, output ready);
endinterface

interface nmab_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [nmab_pkg::CfgIdxW-1:0]     index;
  logic [nmab_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/nmab_line.sv */
`default_nettype none

module nmab_line #(
  parameter int LINE_CAPACITY = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       byte_step_i,
  input  wire logic [nmab_pkg::ByteW-1:0] byte_i,
  input  wire logic                       clear_i,
  output logic                            detect_o
);

  localparam int LenW = $clog2(LINE_CAPACITY);
  localparam logic [LenW-1:0] LastLen = LenW'(LINE_CAPACITY - 1);

  logic [LenW-1:0] len_q, len_d;
  logic            second_g_q, second_g_d;
  logic            comma_q, comma_d;
  logic            star_q, star_d;
  logic            nul_q, nul_d;

  assign detect_o = byte_step_i && (byte_i == nmab_pkg::CHAR_LF) &&
                    second_g_q && comma_q && star_q;

  always_comb begin
    len_d      = len_q;
    second_g_d = second_g_q;
    comma_d    = comma_q;
    star_d     = star_q;
    nul_d      = nul_q;
    if (clear_i || (byte_step_i && (byte_i == nmab_pkg::CHAR_LF)) ||
        (byte_step_i && (byte_i != nmab_pkg::CHAR_CR) && (len_q == LastLen))) begin
      len_d      = '0;
      second_g_d = 1'b0;
      comma_d    = 1'b0;
      star_d     = 1'b0;
      nul_d      = 1'b0;
    end else if (byte_step_i && (byte_i != nmab_pkg::CHAR_CR) &&
                 ((len_q != '0) || (byte_i == nmab_pkg::CHAR_DOLLAR))) begin
      if ((len_q == LenW'(1)) && (byte_i == nmab_pkg::CHAR_G)) begin
        second_g_d = 1'b1;
      end
      if (!nul_q) begin
        if (byte_i == nmab_pkg::CHAR_NUL) begin
          nul_d = 1'b1;
        end else if (byte_i == nmab_pkg::CHAR_COMMA) begin
          comma_d = 1'b1;
        end else if (byte_i == nmab_pkg::CHAR_STAR) begin
          star_d = 1'b1;
        end
      end
      len_d = len_q + LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      second_g_q <= 1'b0;
      comma_q    <= 1'b0;
      star_q     <= 1'b0;
      nul_q      <= 1'b0;
    end else begin
      len_q      <= len_d;
      second_g_q <= second_g_d;
      comma_q    <= comma_d;
      star_q     <= star_d;
      nul_q      <= nul_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/nmab_baud.sv */
`default_nettype none

module nmab_baud #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire nmab_pkg::item_t item_i,
  input  wire nmab_pkg::cfg_t  cfg_i,
  input  wire logic            detect_i,
  output logic                 change_o,
  output nmab_pkg::res_t       res_o
);

  localparam int NowW = (TIME_WIDTH < nmab_pkg::TimeInW) ? TIME_WIDTH : nmab_pkg::TimeInW;

  logic [TIME_WIDTH-1:0]      now_t;
  logic [TIME_WIDTH-1:0]      probe_age;
  logic [TIME_WIDTH-1:0]      sent_age;
  logic                       tick;
  logic                       recent;
  logic [nmab_pkg::BaudW-1:0] baud_q, baud_d;
  logic                       locked_q, locked_d;
  logic [TIME_WIDTH-1:0]      sent_time_q, sent_time_d;
  logic [TIME_WIDTH-1:0]      probe_time_q, probe_time_d;

  assign now_t     = TIME_WIDTH'(item_i.now_ms[NowW-1:0]);
  assign tick      = step_i && (item_i.command == nmab_pkg::CMD_TICK);
  assign probe_age = now_t - probe_time_q;
  assign change_o  = tick && !locked_q &&
                     (probe_age >= TIME_WIDTH'(cfg_i.probe_period_ms));

  // A tick leaves the sentence time alone, so one age check serves lock and health.
  assign sent_time_d = detect_i ? now_t : sent_time_q;
  assign sent_age    = now_t - sent_time_d;
  assign recent      = (sent_time_d != '0) &&
                       (sent_age <= TIME_WIDTH'(cfg_i.healthy_timeout_ms));

  always_comb begin
    baud_d       = baud_q;
    probe_time_d = probe_time_q;
    locked_d     = locked_q;
    if (change_o) begin
      baud_d       = nmab_pkg::next_baud(baud_q, cfg_i.default_baud);
      probe_time_d = now_t;
    end
    if (detect_i) begin
      locked_d = 1'b1;
    end else if (tick && locked_q && !recent) begin
      locked_d = 1'b0;
    end
  end

  always_comb begin
    res_o.current_baud      = baud_d;
    res_o.baud_changed      = change_o;
    res_o.stream_locked     = locked_d;
    res_o.sentence_detected = detect_i;
    res_o.healthy           = cfg_i.enabled && recent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_q       <= nmab_pkg::DEFAULT_BAUD_RST;
      locked_q     <= 1'b0;
      sent_time_q  <= '0;
      probe_time_q <= '0;
    end else begin
      baud_q       <= baud_d;
      locked_q     <= locked_d;
      sent_time_q  <= sent_time_d;
      probe_time_q <= probe_time_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/nmab_cfg_regs.sv */
`default_nettype none

module nmab_cfg_regs (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  nmab_cfg_if.sink        cfg_i,
  output nmab_pkg::cfg_t  cfg_o
);

  nmab_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        nmab_pkg::CFG_ENABLED: begin
          cfg_d.enabled = cfg_i.data[0];
        end
        nmab_pkg::CFG_DEFAULT_BAUD: begin
          cfg_d.default_baud = cfg_i.data[nmab_pkg::BaudW-1:0];
        end
        nmab_pkg::CFG_PROBE_PERIOD: begin
          cfg_d.probe_period_ms = cfg_i.data[nmab_pkg::PeriodW-1:0];
        end
        nmab_pkg::CFG_HEALTHY_TIMEOUT: begin
          cfg_d.healthy_timeout_ms = cfg_i.data[nmab_pkg::PeriodW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled            <= nmab_pkg::ENABLED_RST;
      cfg_q.default_baud       <= nmab_pkg::DEFAULT_BAUD_RST;
      cfg_q.probe_period_ms    <= nmab_pkg::PROBE_PERIOD_RST;
      cfg_q.healthy_timeout_ms <= nmab_pkg::HEALTHY_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/nmab_if_stub_check.sv */
`default_nettype none

module nmab_if_stub_check (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic                       ready_i,
  input  wire logic [nmab_pkg::BaudW-1:0] current_baud_i,
  input  wire logic                       baud_changed_i,
  input  wire logic                       sentence_detected_i
);

  logic hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= valid_i && !ready_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(current_baud_i))
    else $error("Stalled result item changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !(baud_changed_i && sentence_detected_i))
    else $error("A result item shows a baud change and a sentence together.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q |-> valid_i)
    else $error("A stalled result item was dropped.");

endmodule

`default_nettype wire

/* rtl/nmea_autobaud_stream_monitor.sv */
// Channel | Direction | Payload
// in_i    | sink      | command, byte_value, now_ms
// out_o   | source    | current_baud, baud_changed, stream_locked, sentence_detected, healthy
// cfg_i   | sink      | index, data (always ready)
//
// An item is captured in an input register and its result is captured in the output
// register when the item advances, which needs the output register empty or being taken.
// One item is accepted every cycle unless out_o stalls with both stages full; the output
// register and input register keep the input side moving while a result waits to be taken.
// A stall on out_o holds the result and stops the input side once both stages are full.
// Reset clears the line tracker, the lock and both time stamps and loads the baud of 9600.
`default_nettype none

module nmea_autobaud_stream_monitor #(
  parameter int LINE_CAPACITY = 128,
  parameter int TIME_WIDTH    = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nmab_in_if.sink   in_i,
  nmab_out_if.source out_o,
  nmab_cfg_if.sink  cfg_i
);

  nmab_pkg::cfg_t  cfg;
  nmab_pkg::item_t in_q;
  nmab_pkg::res_t  res;
  nmab_pkg::res_t  out_q;
  logic            in_valid_q, in_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            advance;
  logic            step;
  logic            byte_step;
  logic            detect;
  logic            change;

  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign step      = advance && cfg.enabled;
  assign byte_step = step && (in_q.command == nmab_pkg::CMD_BYTE);
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.command    <= in_i.command;
      in_q.byte_value <= in_i.byte_value;
      in_q.now_ms     <= in_i.now_ms;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  nmab_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  nmab_line #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_step_i (byte_step),
    .byte_i      (in_q.byte_value),
    .clear_i     (change),
    .detect_o    (detect)
  );

  nmab_baud #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_baud (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .detect_i (detect),
    .change_o (change),
    .res_o    (res)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.current_baud      = out_q.current_baud;
  assign out_o.baud_changed      = out_q.baud_changed;
  assign out_o.stream_locked     = out_q.stream_locked;
  assign out_o.sentence_detected = out_q.sentence_detected;
  assign out_o.healthy           = out_q.healthy;

  nmab_if_stub_check u_out_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (out_valid_q),
    .ready_i             (out_o.ready),
    .current_baud_i      (out_q.current_baud),
    .baud_changed_i      (out_q.baud_changed),
    .sentence_detected_i (out_q.sentence_detected)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.sentence_detected |-> out_q.stream_locked)
    else $error("A detected sentence did not lock the stream.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.baud_changed |-> !out_q.stream_locked)
    else $error("The baud changed while the stream was locked.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !cfg.enabled |=> !out_q.baud_changed && !out_q.sentence_detected &&
                                !out_q.healthy)
    else $error("A disabled item produced activity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("An item was accepted while both stages were full.");

endmodule

`default_nettype wire

/* dv/tb_nmea_autobaud_stream_monitor.sv */
`timescale 1ns / 100ps

module tb_nmea_autobaud_stream_monitor;
  import nmab_pkg::*;

  localparam int LineCap = 128;

  logic clk;
  logic rst_n;

  nmab_in_if  in_bus ();
  nmab_out_if out_bus ();
  nmab_cfg_if cfg_bus ();

  nmea_autobaud_stream_monitor uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  cfg_t               regs;
  logic [6:0]         line_len;
  logic               second_g;
  logic               comma_f;
  logic               star_f;
  logic               nul_f;
  logic [BaudW-1:0]   baud;
  logic               locked;
  logic [TimeInW-1:0] t_sentence;
  logic [TimeInW-1:0] t_probe;

  item_t              rx_items[$];
  res_t               status_due[$];
  int                 items_queued = 0;
  int                 items_taken = 0;
  int                 err_count = 0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  int                 hold_left = 0;
  logic               calm = 1'b0;
  logic               hold_arm = 1'b0;
  logic               hold_done = 1'b0;
  logic [TimeInW-1:0] clock_ms;

  function automatic void clear_line();
    line_len = '0;
    second_g = 1'b0;
    comma_f  = 1'b0;
    star_f   = 1'b0;
    nul_f    = 1'b0;
  endfunction

  function automatic logic sentence_fresh(input logic [TimeInW-1:0] now);
    logic [TimeInW-1:0] age;
    age = now - t_sentence;
    return (t_sentence != '0) && (age <= TimeInW'(regs.healthy_timeout_ms));
  endfunction

  function automatic logic [BaudW-1:0] baud_after(input logic [BaudW-1:0] cur);
    logic [BaudW-1:0] ladder [5];
    int hit;
    ladder[0] = regs.default_baud;
    ladder[1] = BAUD_9600;
    ladder[2] = BAUD_38400;
    ladder[3] = BAUD_57600;
    ladder[4] = BAUD_115200;
    hit = 0;
    for (int i = 4; i >= 0; i--) begin
      if (ladder[i] == cur) hit = i;
    end
    return ladder[(hit + 1) % 5];
  endfunction

  function automatic logic take_char(input logic [ByteW-1:0] c,
                                     input logic [TimeInW-1:0] now);
    logic good;
    good = 1'b0;
    if (c == CHAR_LF) begin
      good = second_g && comma_f && star_f;
      if (good) begin
        t_sentence = now;
        locked = 1'b1;
      end
      clear_line();
    end else if (c != CHAR_CR) begin
      if (int'(line_len) >= LineCap - 1) begin
        clear_line();
      end else if (line_len != '0 || c == CHAR_DOLLAR) begin
        if (line_len == 7'd1 && c == CHAR_G) second_g = 1'b1;
        if (!nul_f) begin
          if (c == CHAR_NUL) nul_f = 1'b1;
          else if (c == CHAR_COMMA) comma_f = 1'b1;
          else if (c == CHAR_STAR) star_f = 1'b1;
        end
        line_len = line_len + 7'd1;
      end
    end
    return good;
  endfunction

  function automatic logic probe_tick(input logic [TimeInW-1:0] now);
    logic changed;
    logic [TimeInW-1:0] age;
    changed = 1'b0;
    age = now - t_probe;
    if (!locked && age >= TimeInW'(regs.probe_period_ms)) begin
      baud = baud_after(baud);
      t_probe = now;
      clear_line();
      changed = 1'b1;
    end
    if (locked && !sentence_fresh(now)) locked = 1'b0;
    return changed;
  endfunction

  function automatic res_t monitor_step(input item_t it);
    res_t r;
    r = '0;
    if (regs.enabled) begin
      if (it.command == CMD_BYTE) begin
        r.sentence_detected = take_char(it.byte_value, it.now_ms);
      end else begin
        r.baud_changed = probe_tick(it.now_ms);
      end
      r.healthy = sentence_fresh(it.now_ms);
    end
    r.current_baud  = baud;
    r.stream_locked = locked;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    err_count++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_status(input res_t got);
    res_t want;
    if (status_due.size() == 0) begin
      report("unexpected item", 1, 0);
      return;
    end
    want = status_due.pop_front();
    if (got.current_baud != want.current_baud)
      report("current_baud", got.current_baud, want.current_baud);
    if (got.baud_changed != want.baud_changed)
      report("baud_changed", got.baud_changed, want.baud_changed);
    if (got.stream_locked != want.stream_locked)
      report("stream_locked", got.stream_locked, want.stream_locked);
    if (got.sentence_detected != want.sentence_detected)
      report("sentence_detected", got.sentence_detected, want.sentence_detected);
    if (got.healthy != want.healthy)
      report("healthy", got.healthy, want.healthy);
  endtask

  task automatic put_item(input cmd_e cmd, input logic [ByteW-1:0] b,
                          input logic [TimeInW-1:0] now);
    item_t it;
    it.command    = cmd;
    it.byte_value = b;
    it.now_ms     = now;
    rx_items.push_back(it);
    items_queued++;
  endtask

  task automatic put_text(input string s, input logic [TimeInW-1:0] now);
    for (int i = 0; i < s.len(); i++) put_item(CMD_BYTE, s[i], now);
  endtask

  task automatic put_char(input logic [ByteW-1:0] b);
    clock_ms = clock_ms + $urandom_range(0, 2);
    put_item(CMD_BYTE, b, clock_ms);
  endtask

  task automatic put_tick(input logic [TimeInW-1:0] dt);
    clock_ms = clock_ms + dt;
    put_item(CMD_TICK, 8'($urandom_range(0, 255)), clock_ms);
  endtask

  task automatic put_sentence();
    int body;
    int comma_at;
    body = $urandom_range(0, 8);
    comma_at = $urandom_range(0, body);
    put_char(CHAR_DOLLAR);
    put_char(CHAR_G);
    for (int i = 0; i <= body; i++) begin
      if (i == comma_at) put_char(CHAR_COMMA);
      else put_char(8'($urandom_range(8'h30, 8'h5A)));
    end
    put_char(CHAR_STAR);
    put_char(8'($urandom_range(8'h30, 8'h46)));
    put_char(8'($urandom_range(8'h30, 8'h46)));
    if ($urandom_range(0, 1) == 1) put_char(CHAR_CR);
    put_char(CHAR_LF);
  endtask

  task automatic put_broken();
    put_char(CHAR_DOLLAR);
    case ($urandom_range(0, 3))
      0: begin
        put_char(8'($urandom_range(8'h20, 8'h7E)));
        put_char(CHAR_COMMA);
        put_char(CHAR_STAR);
      end
      1: begin
        put_char(CHAR_G);
        put_char(CHAR_NUL);
        put_char(CHAR_COMMA);
        put_char(CHAR_STAR);
      end
      2: begin
        put_char(CHAR_G);
        put_char(CHAR_COMMA);
      end
      default: begin
        put_char(CHAR_G);
        put_char(CHAR_STAR);
        put_char(CHAR_NUL);
        put_char(CHAR_COMMA);
      end
    endcase
    put_char(CHAR_LF);
  endtask

  // A line of 127 characters still ends as a sentence; one more overflows it.
  task automatic put_long_line();
    int len;
    len = LineCap - 2 + $urandom_range(0, 3);
    put_char(CHAR_DOLLAR);
    put_char(CHAR_G);
    put_char(CHAR_COMMA);
    for (int i = 3; i < len - 1; i++) put_char(8'($urandom_range(8'h30, 8'h5A)));
    put_char(CHAR_STAR);
    put_char(CHAR_LF);
  endtask

  task automatic put_random_tick();
    int span;
    span = 2 * int'(regs.probe_period_ms) + 2;
    case ($urandom_range(0, 3))
      0: put_tick($urandom_range(0, 3));
      1: put_tick($urandom_range(0, span));
      2: put_tick(int'(regs.healthy_timeout_ms) + $urandom_range(0, 2));
      default: put_tick(int'(regs.probe_period_ms) - $urandom_range(0, 1));
    endcase
  endtask

  task automatic put_noise();
    if ($urandom_range(0, 2) == 0) begin
      clock_ms = $urandom();
      put_tick(0);
    end else begin
      put_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_mix(input int n);
    int start;
    logic long_done;
    start = items_queued;
    long_done = 1'b0;
    while (items_queued - start < n) begin
      if (!long_done && items_queued - start > n / 2) begin
        put_long_line();
        long_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: put_sentence();
        4, 5, 6: put_random_tick();
        7: put_noise();
        default: put_broken();
      endcase
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_ENABLED: regs.enabled = val[0];
      CFG_DEFAULT_BAUD: regs.default_baud = val[BaudW-1:0];
      CFG_PROBE_PERIOD: regs.probe_period_ms = val[PeriodW-1:0];
      CFG_HEALTHY_TIMEOUT: regs.healthy_timeout_ms = val[PeriodW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int en, input int dflt, input int probe, input int limit);
    write_reg(CFG_ENABLED, CfgDataW'(en));
    write_reg(CFG_DEFAULT_BAUD, CfgDataW'(dflt));
    write_reg(CFG_PROBE_PERIOD, CfgDataW'(probe));
    write_reg(CFG_HEALTHY_TIMEOUT, CfgDataW'(limit));
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while ((items_taken != items_queued || status_due.size() != 0) && guard < 100000);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        status_due.push_back(monitor_step(item_t'({in_bus.command, in_bus.byte_value,
                                                   in_bus.now_ms})));
        items_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (rx_items.size() != 0) begin
          in_bus.valid      <= 1'b1;
          in_bus.command    <= rx_items[0].command;
          in_bus.byte_value <= rx_items[0].byte_value;
          in_bus.now_ms     <= rx_items[0].now_ms;
          rx_items.delete(0);
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        check_status(res_t'({out_bus.current_baud, out_bus.baud_changed,
                             out_bus.stream_locked, out_bus.sentence_detected,
                             out_bus.healthy}));
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (hold_left == 0);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.command    = CMD_BYTE;
    in_bus.byte_value = '0;
    in_bus.now_ms     = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_ENABLED;
    cfg_bus.data      = '0;
    rst_n             = 1'b0;
    regs = {ENABLED_RST, DEFAULT_BAUD_RST, PROBE_PERIOD_RST, HEALTHY_TIMEOUT_RST};
    clear_line();
    baud       = DEFAULT_BAUD_RST;
    locked     = 1'b0;
    t_sentence = '0;
    t_probe    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    put_item(CMD_TICK, 8'hFF, 32'd0);
    put_item(CMD_BYTE, 8'hFF, 32'd0);
    put_item(CMD_TICK, 8'h00, 32'd1800);
    put_text("$G,*\r\n", 32'd0);
    put_item(CMD_TICK, 8'h00, 32'd100);
    put_text("$G", 32'hFFFF_FFFF);
    put_item(CMD_BYTE, CHAR_NUL, 32'hFFFF_FFFF);
    put_text(",*\n", 32'hFFFF_FFFF);
    put_text("$\n\n", 32'hFFFF_FFFF);
    put_text("$G,*\n", 32'hFFFF_FFF0);
    put_item(CMD_TICK, 8'h00, 32'h0000_1390);
    put_item(CMD_TICK, 8'h00, 32'h0000_1390);
    clock_ms = 32'h0000_1390;
    settle();

    set_regs(1, 1200, 1, 1);
    gen_mix(350);
    settle();

    set_regs(1, 4000000, 65535, 65535);
    gen_mix(350);
    settle();

    set_regs(0, 57600, 300, 700);
    gen_mix(150);
    settle();

    set_regs(1, 115200, 2000, 3000);
    gen_mix(450);
    @(posedge clk);
    hold_arm <= 1'b1;
    settle();

    @(posedge clk);
    calm <= 1'b1;
    set_regs(1, $urandom_range(1200, 4000000), $urandom_range(1, 4000),
             $urandom_range(1, 8000));
    gen_mix(450);
    settle();

    if (status_due.size() != 0) report("missing items", status_due.size(), 0);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/nmab_pkg.sv
rtl/nmab_if.sv
rtl/nmab_line.sv
rtl/nmab_baud.sv
rtl/nmab_cfg_regs.sv
rtl/nmab_if_stub_check.sv
rtl/nmea_autobaud_stream_monitor.sv
dv/tb_nmea_autobaud_stream_monitor.sv
